// ----- sv/monotone_chain_convex_hull_assert.svh -----
// Assertion macros shared by the hull block
`ifndef MONOTONE_CHAIN_CONVEX_HULL_ASSERT_SVH
`define MONOTONE_CHAIN_CONVEX_HULL_ASSERT_SVH

// Condition that holds at every clock edge out of reset
`define MCH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define MCH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mchull_pkg.sv -----
// Package: command and status types between hull controller and datapath
package mchull_pkg;

  typedef struct packed {
    logic ld_en;       // load state: take points
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic rd_j;        // store read address from j instead of i
    logic pi_load;     // latch point i
    logic dup_chk;     // flag point i duplicate on match
    logic dup_wr;      // write the duplicate mark of point i into the store
    logic rank_clr;
    logic rank_chk;    // count a smaller distinct point
    logic srt_wr;      // write point i into sorted slot
    logic h_start;     // begin upper chain
    logic c_load;      // latch candidate point
    logic diff_load;   // register turn differences
    logic mul_load;    // register cross products
    logic push;
    logic pop;
    logic t0_load;     // refill second-from-top after pop
    logic chain_next;  // upper done, begin lower
    logic lower_done;  // lower done, set up emit
    logic e_out;       // load output register
    logic set_clear;   // clear count and overflow
  } mchull_cmd_t;

  typedef struct packed {
    logic in_last;
    logic i_end;
    logic j_eq_i;
    logic j_end;
    logic dup_i;
    logic s_end;
    logic sp_lt2;
    logic lower;
    logic right;
    logic e_end;
    logic out_free;
  } mchull_sts_t;

endpackage

// ----- sv/mchull_ifs.sv -----
// Interfaces: point input channel and hull vertex output channel
interface mchull_pt_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface mchull_vx_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;
  logic                         overflowed;

  modport source (output valid, vertex_x, vertex_y, last_vertex, overflowed, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, overflowed, output ready);
endinterface

// ----- sv/mchull_ctrl.sv -----
// Controller: sequences load, sort, hull passes and vertex emit
module mchull_ctrl
  import mchull_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mchull_sts_t sts,
  output mchull_cmd_t cmd
);

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_A_I  = 5'd1;
  localparam logic [4:0] S_A_IL = 5'd2;
  localparam logic [4:0] S_A_J  = 5'd3;
  localparam logic [4:0] S_A_JC = 5'd4;
  localparam logic [4:0] S_B_I  = 5'd5;
  localparam logic [4:0] S_B_IL = 5'd6;
  localparam logic [4:0] S_B_J  = 5'd7;
  localparam logic [4:0] S_B_JC = 5'd8;
  localparam logic [4:0] S_H_RD = 5'd9;
  localparam logic [4:0] S_H_C  = 5'd10;
  localparam logic [4:0] S_H_T  = 5'd11;
  localparam logic [4:0] S_H_M  = 5'd12;
  localparam logic [4:0] S_H_X  = 5'd13;
  localparam logic [4:0] S_H_PL = 5'd14;
  localparam logic [4:0] S_E_RD = 5'd15;
  localparam logic [4:0] S_E_W  = 5'd16;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.ld_en = 1'b1;
        if (sts.in_last) state_nxt = S_A_I;
      end
      // duplicate marking pass
      S_A_I: begin
        if (sts.i_end) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_B_I;
        end else begin
          state_nxt = S_A_IL;
        end
      end
      S_A_IL: begin
        cmd.pi_load = 1'b1;
        cmd.j_clr   = 1'b1;
        state_nxt   = S_A_J;
      end
      S_A_J: begin
        if (sts.j_eq_i) begin
          cmd.dup_wr = 1'b1;
          cmd.i_inc  = 1'b1;
          state_nxt  = S_A_I;
        end else begin
          cmd.rd_j  = 1'b1;
          state_nxt = S_A_JC;
        end
      end
      S_A_JC: begin
        cmd.dup_chk = 1'b1;
        cmd.j_inc   = 1'b1;
        state_nxt   = S_A_J;
      end
      // rank pass: place each distinct point at its sorted slot
      S_B_I: begin
        if (sts.i_end) begin
          cmd.h_start = 1'b1;
          state_nxt   = S_H_RD;
        end else begin
          state_nxt = S_B_IL;
        end
      end
      S_B_IL: begin
        if (sts.dup_i) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_B_I;
        end else begin
          cmd.pi_load  = 1'b1;
          cmd.rank_clr = 1'b1;
          cmd.j_clr    = 1'b1;
          state_nxt    = S_B_J;
        end
      end
      S_B_J: begin
        if (sts.j_end) begin
          cmd.srt_wr = 1'b1;
          cmd.i_inc  = 1'b1;
          state_nxt  = S_B_I;
        end else begin
          cmd.rd_j  = 1'b1;
          state_nxt = S_B_JC;
        end
      end
      S_B_JC: begin
        cmd.rank_chk = 1'b1;
        cmd.j_inc    = 1'b1;
        state_nxt    = S_B_J;
      end
      // chain building
      S_H_RD: begin
        if (sts.s_end) begin
          if (sts.lower) begin
            cmd.lower_done = 1'b1;
            state_nxt      = S_E_RD;
          end else begin
            cmd.chain_next = 1'b1;
          end
        end else begin
          state_nxt = S_H_C;
        end
      end
      S_H_C: begin
        cmd.c_load = 1'b1;
        state_nxt  = S_H_T;
      end
      S_H_T: begin
        if (sts.sp_lt2) begin
          cmd.push  = 1'b1;
          state_nxt = S_H_RD;
        end else begin
          cmd.diff_load = 1'b1;
          state_nxt     = S_H_M;
        end
      end
      S_H_M: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_H_X;
      end
      S_H_X: begin
        if (sts.right) begin
          cmd.push  = 1'b1;
          state_nxt = S_H_RD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_H_PL;
        end
      end
      S_H_PL: begin
        cmd.t0_load = 1'b1;
        state_nxt   = S_H_T;
      end
      // emit
      S_E_RD: begin
        if (sts.e_end) begin
          cmd.set_clear = 1'b1;
          state_nxt     = S_LOAD;
        end else begin
          state_nxt = S_E_W;
        end
      end
      S_E_W: begin
        if (sts.out_free) begin
          cmd.e_out = 1'b1;
          state_nxt = S_E_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

// ----- sv/mchull_dp.sv -----
// Datapath: point store, sorted store, hull stack, turn test, output register
module mchull_dp
  import mchull_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mchull_cmd_t cmd,
  output mchull_sts_t sts,
  mchull_pt_if.sink   in_pt,
  mchull_vx_if.source out_vx
);

`include "monotone_chain_convex_hull_assert.svh"

  localparam int CB    = COORD_BITS;
  localparam int PTW   = 2 * CB;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int STK_W = $clog2(2 * MAX_POINTS);
  localparam int TOT_W = CNT_W + 1;
  localparam int DW    = CB + 1;
  localparam int PW    = 2 * DW;

  // memories; the point store keeps a duplicate mark above each point
  logic [PTW:0]   st_mem  [MAX_POINTS];
  logic [PTW-1:0] srt_mem [MAX_POINTS];
  logic [PTW-1:0] stk_mem [2*MAX_POINTS];
  logic [PTW:0]   pd_r;
  logic [PTW-1:0] sd_r, kd_r;

  logic [CNT_W-1:0] cnt_r, i_r, j_r, n_r, rank_r, s_r, sp_r, u_r;
  logic             ovf_r, lower_r;
  logic             dup_r;
  logic [PTW-1:0]   pi_r, c_r, t0_r, t1_r;
  logic [TOT_W-1:0] e_r, total_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [PW-1:0] prod_p_r, prod_q_r;
  logic             out_valid_r, olast_r, oovf_r;
  logic [PTW-1:0]   opt_r;

  logic             accept, room;
  logic [IDX_W-1:0] st_addr, srt_addr;
  logic [CNT_W-1:0] h_pos;
  logic [STK_W-1:0] base, push_addr, pop_addr, emit_addr, stk_addr;
  logic [TOT_W-1:0] e_off;
  logic signed [CB-1:0] pd_x, pd_y, pi_x, pi_y;
  logic signed [CB-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic             pt_eq, pt_less, out_free;

  assign accept = cmd.ld_en && in_pt.valid;
  assign room   = (cnt_r < CNT_W'(MAX_POINTS));
  assign in_pt.ready = cmd.ld_en;

  assign pd_x = pd_r[PTW-1:CB];
  assign pd_y = pd_r[CB-1:0];
  assign pi_x = pi_r[PTW-1:CB];
  assign pi_y = pi_r[CB-1:0];
  assign a_x  = t0_r[PTW-1:CB];
  assign a_y  = t0_r[CB-1:0];
  assign b_x  = t1_r[PTW-1:CB];
  assign b_y  = t1_r[CB-1:0];
  assign c_x  = c_r[PTW-1:CB];
  assign c_y  = c_r[CB-1:0];

  assign pt_eq   = (pd_r[PTW-1:0] == pi_r);
  assign pt_less = (pd_x < pi_x) || ((pd_x == pi_x) && (pd_y < pi_y));

  assign st_addr  = cmd.rd_j ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign h_pos    = lower_r ? (n_r - CNT_W'(1) - s_r) : s_r;
  assign srt_addr = h_pos[IDX_W-1:0];

  assign base      = lower_r ? STK_W'(MAX_POINTS) : '0;
  assign push_addr = base + STK_W'(sp_r);
  assign pop_addr  = base + STK_W'(sp_r) - STK_W'(3);
  assign e_off     = e_r - TOT_W'(u_r) + TOT_W'(1);
  assign emit_addr = (e_r < TOT_W'(u_r)) ? STK_W'(e_r) : STK_W'(MAX_POINTS) + STK_W'(e_off);
  assign stk_addr  = cmd.pop ? pop_addr : emit_addr;

  assign out_free = !out_valid_r || out_vx.ready;

  // point store: load writes at the count, the duplicate pass writes the mark
  always_ff @(posedge clk) begin
    if (accept && room) begin
      st_mem[cnt_r[IDX_W-1:0]] <= {1'b0, in_pt.point_x, in_pt.point_y};
    end else if (cmd.dup_wr) begin
      st_mem[i_r[IDX_W-1:0]] <= {dup_r, pi_r};
    end
    pd_r <= st_mem[st_addr];
  end

  // sorted store
  always_ff @(posedge clk) begin
    if (cmd.srt_wr) begin
      srt_mem[rank_r[IDX_W-1:0]] <= pi_r;
    end
    sd_r <= srt_mem[srt_addr];
  end

  // hull stack
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[push_addr] <= c_r;
    end
    kd_r <= stk_mem[stk_addr];
  end

  // count and overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.set_clear) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (room) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // sort pass registers
  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      i_r <= '0;
      n_r <= '0;
    end else begin
      if (cmd.i_clr) i_r <= '0;
      else if (cmd.i_inc) i_r <= i_r + CNT_W'(1);
      if (cmd.srt_wr) n_r <= n_r + CNT_W'(1);
    end
    if (cmd.j_clr) begin
      j_r   <= '0;
      dup_r <= 1'b0;
    end else begin
      if (cmd.j_inc) j_r <= j_r + CNT_W'(1);
      if (cmd.dup_chk && pt_eq) dup_r <= 1'b1;
    end
    if (cmd.pi_load) pi_r <= pd_r[PTW-1:0];
    if (cmd.rank_clr) begin
      rank_r <= '0;
    end else if (cmd.rank_chk && !pd_r[PTW] && pt_less) begin
      rank_r <= rank_r + CNT_W'(1);
    end
  end

  // chain registers and turn test
  always_ff @(posedge clk) begin
    if (cmd.h_start) begin
      s_r     <= '0;
      sp_r    <= '0;
      lower_r <= 1'b0;
    end else if (cmd.chain_next) begin
      u_r     <= sp_r;
      s_r     <= '0;
      sp_r    <= '0;
      lower_r <= 1'b1;
    end else if (cmd.push) begin
      sp_r <= sp_r + CNT_W'(1);
      s_r  <= s_r + CNT_W'(1);
      t0_r <= t1_r;
      t1_r <= c_r;
    end else if (cmd.pop) begin
      sp_r <= sp_r - CNT_W'(1);
      t1_r <= t0_r;
    end else if (cmd.t0_load) begin
      t0_r <= kd_r;
    end
    if (cmd.c_load) c_r <= sd_r;
    if (cmd.diff_load) begin
      dx1_r <= DW'(b_x) - DW'(a_x);
      dy1_r <= DW'(b_y) - DW'(a_y);
      dx2_r <= DW'(c_x) - DW'(a_x);
      dy2_r <= DW'(c_y) - DW'(a_y);
    end
    if (cmd.mul_load) begin
      prod_p_r <= PW'(dx1_r) * PW'(dy2_r);
      prod_q_r <= PW'(dy1_r) * PW'(dx2_r);
    end
    if (cmd.lower_done) begin
      total_r <= (n_r == CNT_W'(1)) ? TOT_W'(1)
                                    : TOT_W'(u_r) + TOT_W'(sp_r) - TOT_W'(2);
      e_r     <= '0;
    end else if (cmd.e_out) begin
      e_r <= e_r + TOT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.e_out) begin
      out_valid_r <= 1'b1;
    end else if (out_vx.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.e_out) begin
      opt_r   <= kd_r;
      olast_r <= (e_r == total_r - TOT_W'(1));
      oovf_r  <= ovf_r;
    end
  end

  assign out_vx.valid       = out_valid_r;
  assign out_vx.vertex_x    = opt_r[PTW-1:CB];
  assign out_vx.vertex_y    = opt_r[CB-1:0];
  assign out_vx.last_vertex = olast_r;
  assign out_vx.overflowed  = oovf_r;

  always_comb begin
    sts          = '0;
    sts.in_last  = in_pt.valid && in_pt.last_point;
    sts.i_end    = (i_r == cnt_r);
    sts.j_eq_i   = (j_r == i_r);
    sts.j_end    = (j_r == cnt_r);
    sts.dup_i    = pd_r[PTW];
    sts.s_end    = (s_r == n_r);
    sts.sp_lt2   = (sp_r < CNT_W'(2));
    sts.lower    = lower_r;
    sts.right    = (prod_p_r < prod_q_r);
    sts.e_end    = (e_r == total_r);
    sts.out_free = out_free;
  end

  `MCH_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(MAX_POINTS), "point count past capacity")
  `MCH_ASSERT_IMPLY(a_ovf_full, ovf_r, cnt_r == CNT_W'(MAX_POINTS), "overflow with room left")
  `MCH_ASSERT_IMPLY(a_push_room, cmd.push, sp_r < CNT_W'(MAX_POINTS), "hull stack overrun")
  `MCH_ASSERT_IMPLY(a_srt_room, cmd.srt_wr, n_r < cnt_r, "more sorted points than stored")
  `MCH_ASSERT_NEXT(a_out_load, cmd.e_out, out_valid_r, "vertex load lost")

endmodule

// ----- sv/monotone_chain_convex_hull.sv -----
// Top level: convex hull of a point set by the monotone chain method
//
// Points stream in on in_pt, one transaction per cycle, until the one that
// carries last_point. Up to MAX_POINTS points are kept; later ones are
// dropped and every vertex of that set reports overflowed. After the last
// point the block stops taking input, sorts the set by x then y (exact
// duplicates merged), builds the upper chain left to right and the lower
// chain right to left, dropping collinear middles, and sends the clockwise
// vertex run on out_vx, last_vertex on its final vertex. A single distinct
// point comes out alone. The sort runs through the single read port of the
// point store, first marking duplicates, then ranking each distinct point.
// Each chain step goes through the shared turn test (differences, products,
// compare), with a stack refill read on each pop. Emit waits while out_vx
// still holds an unaccepted vertex. No clearing pass follows reset; input
// is taken again once the last vertex has been loaded for output.
module monotone_chain_convex_hull
  import mchull_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mchull_pt_if.sink   in_pt,
  mchull_vx_if.source out_vx
);

  // command and status between sequencer and datapath
  mchull_cmd_t cmd;
  mchull_sts_t sts;

  // sequence load, sort, hull and emit
  mchull_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // hold points, sorted set, stack and output transaction register
  mchull_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_pt  (in_pt),
    .out_vx (out_vx)
  );

endmodule

// ----- sim/tb_hull_ifs.sv -----
// Testbench copies are not needed: interfaces come from the RTL; this file holds shared tb types
`timescale 1ns / 1ps
package tb_hull_pkg;
  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               lastv;
    logic               ovf;
  } vertex_t;
endpackage

// ----- sim/tb_top.sv -----
// Testbench top: drives point sets into the hull block and checks every vertex
`timescale 1ns / 1ps
module tb_top;
  import tb_hull_pkg::*;

  localparam int MAXP = 64;
  localparam int WDOG_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mchull_pt_if #(.COORD_BITS(16)) in_pt ();
  mchull_vx_if #(.COORD_BITS(16)) out_vx ();

  monotone_chain_convex_hull #(.MAX_POINTS(MAXP), .COORD_BITS(16)) uut (
    .clk(clk), .rst_n(rst_n), .in_pt(in_pt.sink), .out_vx(out_vx.source)
  );

  // Predictor state: the current set and its overflow flag
  logic signed [15:0] set_x[$];
  logic signed [15:0] set_y[$];
  logic set_ovf;
  vertex_t hull_expected[$];

  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Compare by x then y
  function automatic bit pt_less(input logic signed [15:0] ax, ay, bx, by);
    if (ax != bx) return ax < bx;
    return ay < by;
  endfunction

  // Strict clockwise turn a -> b -> c; 34-bit products are exact in 64 bits
  function automatic bit cw_turn(input logic signed [15:0] ax, ay, bx, by, cx, cy);
    longint dx1, dy1, dx2, dy2;
    dx1 = longint'(bx) - longint'(ax);
    dy1 = longint'(by) - longint'(ay);
    dx2 = longint'(cx) - longint'(ax);
    dy2 = longint'(cy) - longint'(ay);
    return dx1 * dy2 < dy1 * dx2;
  endfunction

  // Build the clockwise hull of the current set and queue its vertices
  task automatic predict_hull();
    int ord[$];
    int up[$];
    int lo[$];
    int j, n, total;
    bit dup;
    vertex_t v;
    for (int i = 0; i < set_x.size(); i++) begin
      dup = 0;
      foreach (ord[k]) if (set_x[ord[k]] == set_x[i] && set_y[ord[k]] == set_y[i]) dup = 1;
      if (!dup) begin
        j = 0;
        while (j < ord.size() && !pt_less(set_x[i], set_y[i], set_x[ord[j]], set_y[ord[j]]))
          j++;
        ord.insert(j, i);
      end
    end
    n = ord.size();
    v.ovf = set_ovf;
    if (n == 1) begin
      v.vx = set_x[ord[0]]; v.vy = set_y[ord[0]]; v.lastv = 1'b1;
      hull_expected.insert(hull_expected.size(), v);
    end else begin
      for (int i = 0; i < n; i++) begin
        while (up.size() >= 2 && !cw_turn(set_x[up[$-1]], set_y[up[$-1]], set_x[up[$]],
               set_y[up[$]], set_x[ord[i]], set_y[ord[i]]))
          void'(up.pop_back());
        up.insert(up.size(), ord[i]);
      end
      for (int i = n - 1; i >= 0; i--) begin
        while (lo.size() >= 2 && !cw_turn(set_x[lo[$-1]], set_y[lo[$-1]], set_x[lo[$]],
               set_y[lo[$]], set_x[ord[i]], set_y[ord[i]]))
          void'(lo.pop_back());
        lo.insert(lo.size(), ord[i]);
      end
      // Drop the lower chain's end points; they repeat the upper chain's ends
      void'(lo.pop_back());
      void'(lo.pop_front());
      up = {up, lo};
      total = up.size();
      foreach (up[k]) begin
        v.vx = set_x[up[k]]; v.vy = set_y[up[k]]; v.lastv = (k == total - 1);
        hull_expected.insert(hull_expected.size(), v);
      end
    end
    set_x.delete();
    set_y.delete();
    set_ovf = 1'b0;
  endtask

  // Send one point; hold valid until the transaction completes
  task automatic send_point(input logic signed [15:0] px, py, input bit lastp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
    in_pt.valid <= 1'b1;
    in_pt.point_x <= px;
    in_pt.point_y <= py;
    in_pt.last_point <= lastp;
    do @(posedge clk); while (!in_pt.ready);
    // Update the predictor at acceptance
    if (set_x.size() < MAXP) begin
      set_x.insert(set_x.size(), px);
      set_y.insert(set_y.size(), py);
    end else begin
      set_ovf = 1'b1;
    end
    if (lastp) predict_hull();
  endtask

  // Send a whole set, then drop valid
  task automatic send_set(input logic signed [15:0] xs[$], input logic signed [15:0] ys[$]);
    foreach (xs[k]) send_point(xs[k], ys[k], k == xs.size() - 1);
    in_pt.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (hull_expected.size() != 0) @(posedge clk);
  endtask

  // Draw a coordinate; mostly a narrow box so collinear and duplicate points occur
  function automatic logic signed [15:0] rand_coord(input int spread);
    if (spread == 0) return 16'($urandom);
    return 16'($signed($urandom_range(2 * spread)) - spread);
  endfunction

  task automatic send_random_set(input int npts, input int spread);
    logic signed [15:0] xs[$];
    logic signed [15:0] ys[$];
    for (int k = 0; k < npts; k++) begin
      xs.insert(xs.size(), rand_coord(spread));
      ys.insert(ys.size(), rand_coord(spread));
    end
    send_set(xs, ys);
  endtask

  // Result checker: compare each accepted vertex with the oldest expectation
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n) begin
      out_vx.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      if (out_vx.valid && out_vx.ready) begin
        if (hull_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected vertex (%0d,%0d)",
                                    out_vx.vertex_x, out_vx.vertex_y));
        end else begin
          e = hull_expected.pop_front();
          if (out_vx.vertex_x !== e.vx)
            report_mismatch($sformatf("vertex_x %0d, want %0d", out_vx.vertex_x, e.vx));
          if (out_vx.vertex_y !== e.vy)
            report_mismatch($sformatf("vertex_y %0d, want %0d", out_vx.vertex_y, e.vy));
          if (out_vx.last_vertex !== e.lastv)
            report_mismatch($sformatf("last_vertex %0b, want %0b", out_vx.last_vertex, e.lastv));
          if (out_vx.overflowed !== e.ovf)
            report_mismatch($sformatf("overflowed %0b, want %0b", out_vx.overflowed, e.ovf));
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_pt.valid && in_pt.ready) || (out_vx.valid && out_vx.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Directed: extremes, single point, duplicates, two points, collinear, square
  task automatic test_directed();
    send_set({16'sh7fff}, {-16'sh8000});
    send_set({5, 5, 5}, {-3, -3, -3});
    send_set({-16'sh8000, 16'sh7fff}, {16'sh7fff, -16'sh8000});
    send_set({0, 3, 1, 2}, {0, 3, 1, 2});
    send_set({-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 0},
             {-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 0});
    send_set({0, 4, 4, 0, 2, 4, 2}, {0, 0, 4, 4, 0, 2, 2});
    send_set({16'shaaaa, 16'sh5555, 16'sh0f0f}, {16'sh5555, 16'shaaaa, 16'shf0f0});
  endtask

  // Overflow: sets past the store's capacity, last point dropped too, and one set exactly at capacity
  task automatic test_overflow();
    send_random_set(MAXP + 3, 0);
    send_random_set(MAXP, 50);
    send_random_set(MAXP + 1, 3);
  endtask

  // Random sets under one idling phase; pause once for a full drain
  task automatic test_random(input int sip, input int rsp, input int nitems);
    int sent;
    send_idle_pct = sip;
    recv_stall_pct = rsp;
    sent = 0;
    while (sent < nitems) begin
      int npts;
      npts = ($urandom_range(9) == 0) ? $urandom_range(MAXP, 20) : $urandom_range(12, 1);
      case ($urandom_range(3))
        0: send_random_set(npts, 0);
        1: send_random_set(npts, 4);
        default: send_random_set(npts, 200);
      endcase
      sent += npts;
    end
    wait_drain();
  endtask

  initial begin
    in_pt.valid = 1'b0;
    in_pt.point_x = '0;
    in_pt.point_y = '0;
    in_pt.last_point = 1'b0;
    out_vx.ready = 1'b0;
    set_ovf = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    wait_drain();
    test_random(0, 0, 65);
    test_random(57, 0, 65);
    test_random(0, 57, 65);
    test_random(22, 22, 65);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drain();
    repeat (200) @(posedge clk);
    if (err_count == 0 && hull_expected.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/mchull_pkg.sv
sv/mchull_ifs.sv
sv/mchull_ctrl.sv
sv/mchull_dp.sv
sv/monotone_chain_convex_hull.sv
sim/tb_hull_ifs.sv
sim/tb_top.sv
